// ===== sv/ptrf_pkg.sv =====
// shared types and constants of the point transform and region filter
package ptrf_pkg;

   // axis slots of a packed coordinate triple
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // register indexes (byte address is 8 * index)
   localparam logic [2:0] REG_MOUNT    = 3'd0;
   localparam logic [2:0] REG_ROT_X    = 3'd1;
   localparam logic [2:0] REG_ROT_Y    = 3'd2;
   localparam logic [2:0] REG_ROT_Z    = 3'd3;
   localparam logic [2:0] REG_OFFSET   = 3'd4;
   localparam logic [2:0] REG_TAN_VIEW = 3'd5;
   localparam logic [2:0] REG_TAN_BACK = 3'd6;

   // mount positions
   localparam logic [2:0] MOUNT_FACE  = 3'd1;
   localparam logic [2:0] MOUNT_CHIN  = 3'd2;
   localparam logic [2:0] MOUNT_LEFT  = 3'd3;
   localparam logic [2:0] MOUNT_RIGHT = 3'd4;
   localparam logic [2:0] MOUNT_REAR  = 3'd5;

   // tan(40 deg) in Q4.12
   localparam logic [15:0] TAN40_Q12 = 16'd3437;

   // rounding constant for the Q2.14 product sum
   localparam logic signed [33:0] ROUND_HALF = 34'sd8192;

   // crop limits in millimetres
   localparam logic signed [15:0] BZ_MAX      = 16'sd150;
   localparam logic signed [15:0] FACE_PX_MIN = 16'sd50;
   localparam logic signed [15:0] FACE_PY_LIM = 16'sd500;
   localparam logic signed [15:0] SIDE_PY_MIN = 16'sd100;
   localparam logic signed [15:0] SIDE_PX_LIM = 16'sd350;
   localparam logic signed [15:0] REAR_BZ_MAX = -16'sd50;
   localparam logic signed [15:0] REAR_BY_LIM = 16'sd350;
   localparam logic signed [15:0] REAR_BX_LIM = 16'sd800;

   typedef logic [2:0][15:0] vec3_type;

   typedef struct packed {
      logic [2:0]            mount_mode;
      logic [2:0][2:0][15:0] rot;        // [body axis][camera axis]
      vec3_type              offs;
      logic [15:0]           tan_view;
      logic [15:0]           tan_back;
   } cfg_type;

   typedef struct packed {
      vec3_type  xyz;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   typedef struct packed {
      pix_type               pix;
      logic [2:0][2:0][31:0] prod;
      logic [2:0][16:0]      mag;
      logic [32:0]           tv_px;
      logic [32:0]           tv_py;
      logic [32:0]           tb_px;
      logic [32:0]           t40_px;
      logic [32:0]           t40_py;
   } prod_type;

   typedef struct packed {
      pix_type          pix;
      logic [2:0][19:0] q;
      logic             lt_zx_view;
      logic             lt_zy_view;
      logic             lt_zx_back;
      logic             lt_xy_40;
      logic             lt_yx_40;
   } sum_type;

endpackage

// ===== sv/ptrf_csr.sv =====
// configuration register file behind the apb-style port
module ptrf_csr import ptrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [2:0]  mount_ff, mount_in;
   logic [47:0] rot_x_ff, rot_x_in;
   logic [47:0] rot_y_ff, rot_y_in;
   logic [47:0] rot_z_ff, rot_z_in;
   logic [47:0] offs_ff, offs_in;
   logic [15:0] tan_view_ff, tan_view_in;
   logic [15:0] tan_back_ff, tan_back_in;
   logic        wr_en;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[5:3];

   always_comb begin
      mount_in    = mount_ff;
      rot_x_in    = rot_x_ff;
      rot_y_in    = rot_y_ff;
      rot_z_in    = rot_z_ff;
      offs_in     = offs_ff;
      tan_view_in = tan_view_ff;
      tan_back_in = tan_back_ff;
      if (wr_en) begin
         case (idx)
            REG_MOUNT:    mount_in    = csr_pwdata[2:0];
            REG_ROT_X:    rot_x_in    = csr_pwdata[47:0];
            REG_ROT_Y:    rot_y_in    = csr_pwdata[47:0];
            REG_ROT_Z:    rot_z_in    = csr_pwdata[47:0];
            REG_OFFSET:   offs_in     = csr_pwdata[47:0];
            REG_TAN_VIEW: tan_view_in = csr_pwdata[15:0];
            REG_TAN_BACK: tan_back_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mount_ff    <= MOUNT_FACE;
         rot_x_ff    <= 48'h0000_0000_4000;
         rot_y_ff    <= 48'h0000_4000_0000;
         rot_z_ff    <= 48'h4000_0000_0000;
         offs_ff     <= 48'h0;
         tan_view_ff <= 16'd1910;
         tan_back_ff <= 16'd2737;
      end else begin
         mount_ff    <= mount_in;
         rot_x_ff    <= rot_x_in;
         rot_y_ff    <= rot_y_in;
         rot_z_ff    <= rot_z_in;
         offs_ff     <= offs_in;
         tan_view_ff <= tan_view_in;
         tan_back_ff <= tan_back_in;
      end
   end

   always_comb begin
      case (idx)
         REG_MOUNT:    csr_prdata = {61'b0, mount_ff};
         REG_ROT_X:    csr_prdata = {16'b0, rot_x_ff};
         REG_ROT_Y:    csr_prdata = {16'b0, rot_y_ff};
         REG_ROT_Z:    csr_prdata = {16'b0, rot_z_ff};
         REG_OFFSET:   csr_prdata = {16'b0, offs_ff};
         REG_TAN_VIEW: csr_prdata = {48'b0, tan_view_ff};
         REG_TAN_BACK: csr_prdata = {48'b0, tan_back_ff};
         default:      csr_prdata = 64'b0;
      endcase
   end

   assign cfg.mount_mode = mount_ff;
   assign cfg.rot        = {rot_z_ff, rot_y_ff, rot_x_ff};
   assign cfg.offs       = offs_ff;
   assign cfg.tan_view   = tan_view_ff;
   assign cfg.tan_back   = tan_back_ff;

endmodule

// ===== sv/ptrf_mul.sv =====
// input register with magnitudes, then registered rotation and ratio products
module ptrf_mul import ptrf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     up_valid,
   output logic     up_ready,
   input  pix_type  up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output prod_type dn_data
);

   // stage a: captured point and coordinate magnitudes
   logic             a_v_ff, a_v_in;
   pix_type          a_pix_ff;
   logic [2:0][16:0] a_mag_ff, a_mag_in;
   logic             a_ready;

   // stage b: products
   logic             b_v_ff, b_v_in;
   prod_type         b_ff, b_in;
   logic             b_ready;

   assign b_ready  = ~b_v_ff | dn_ready;
   assign a_ready  = ~a_v_ff | b_ready;
   assign up_ready = a_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (up_data.xyz[i][15])
            a_mag_in[i] = 17'd0 - {up_data.xyz[i][15], up_data.xyz[i]};
         else
            a_mag_in[i] = {1'b0, up_data.xyz[i]};
      end
   end

   assign a_v_in = a_ready ? up_valid : a_v_ff;
   assign b_v_in = b_ready ? a_v_ff : b_v_ff;

   always_comb begin
      b_in     = b_ff;
      b_in.pix = a_pix_ff;
      b_in.mag = a_mag_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            b_in.prod[r][c] = 32'($signed(cfg.rot[r][c])) * 32'($signed(a_pix_ff.xyz[c]));
         end
      end
      b_in.tv_px  = 33'(cfg.tan_view) * 33'(a_mag_ff[AXIS_X]);
      b_in.tv_py  = 33'(cfg.tan_view) * 33'(a_mag_ff[AXIS_Y]);
      b_in.tb_px  = 33'(cfg.tan_back) * 33'(a_mag_ff[AXIS_X]);
      b_in.t40_px = 33'(TAN40_Q12) * 33'(a_mag_ff[AXIS_X]);
      b_in.t40_py = 33'(TAN40_Q12) * 33'(a_mag_ff[AXIS_Y]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid & a_ready) begin
         a_pix_ff <= up_data;
         a_mag_ff <= a_mag_in;
      end
      if (a_v_ff & b_ready)
         b_ff <= b_in;
   end

   assign dn_valid = b_v_ff;
   assign dn_data  = b_ff;

endmodule

// ===== sv/ptrf_sum.sv =====
// product sums with rounding, and the cross-multiplied ratio compares
module ptrf_sum import ptrf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  prod_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output sum_type  dn_data
);

   logic        v_ff, v_in;
   sum_type     s_ff, s_in;
   logic signed [33:0] acc [3];
   logic [32:0] sh_px, sh_py, sh_pz;

   assign up_ready = ~v_ff | dn_ready;
   assign v_in     = up_ready ? up_valid : v_ff;

   // magnitude times 4096
   assign sh_px = {4'b0, up_data.mag[AXIS_X], 12'b0};
   assign sh_py = {4'b0, up_data.mag[AXIS_Y], 12'b0};
   assign sh_pz = {4'b0, up_data.mag[AXIS_Z], 12'b0};

   always_comb begin
      s_in     = s_ff;
      s_in.pix = up_data.pix;
      for (int r = 0; r < 3; r++) begin
         acc[r] = 34'($signed(up_data.prod[r][0])) + 34'($signed(up_data.prod[r][1]))
                + 34'($signed(up_data.prod[r][2])) + ROUND_HALF;
         // floor of the rounded sum over 2^14
         s_in.q[r] = acc[r][33:14];
      end
      s_in.lt_zx_view = sh_pz < up_data.tv_px;
      s_in.lt_zy_view = sh_pz < up_data.tv_py;
      s_in.lt_zx_back = sh_pz < up_data.tb_px;
      s_in.lt_xy_40   = sh_px < up_data.t40_py;
      s_in.lt_yx_40   = sh_py < up_data.t40_px;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= 1'b0;
      else
         v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (up_valid & up_ready)
         s_ff <= s_in;
   end

   assign dn_valid = v_ff;
   assign dn_data  = s_ff;

endmodule

// ===== sv/ptrf_crop.sv =====
// offset add with saturation, crop rule and output register
module ptrf_crop import ptrf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    up_valid,
   output logic    up_ready,
   input  sum_type up_data,
   output logic    dn_valid,
   input  logic    dn_ready,
   output pix_type dn_data
);

   logic               v_ff, v_in;
   pix_type            o_ff, o_in;
   logic signed [20:0] tot [3];
   logic signed [15:0] b [3];
   logic signed [15:0] px, py;
   logic               keep;

   assign up_ready = ~v_ff | dn_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tot[i] = $signed({up_data.q[i][19], up_data.q[i]})
                + $signed({{5{cfg.offs[i][15]}}, cfg.offs[i]});
         if (tot[i][20:15] == 6'b000000 || tot[i][20:15] == 6'b111111)
            b[i] = tot[i][15:0];
         else if (tot[i][20])
            b[i] = 16'sh8000;
         else
            b[i] = 16'sh7fff;
      end
   end

   assign px = up_data.pix.xyz[AXIS_X];
   assign py = up_data.pix.xyz[AXIS_Y];

   always_comb begin
      case (cfg.mount_mode)
         MOUNT_FACE:
            keep = !(b[AXIS_Z] > BZ_MAX || px < FACE_PX_MIN || up_data.lt_xy_40)
                 && (py < FACE_PY_LIM && py > -FACE_PY_LIM);
         MOUNT_CHIN:
            keep = !(up_data.lt_zx_view || up_data.lt_zy_view
                     || (up_data.lt_zx_back && px[15]));
         MOUNT_LEFT:
            keep = !(b[AXIS_Z] > BZ_MAX || up_data.lt_yx_40)
                 && (py > SIDE_PY_MIN && px < SIDE_PX_LIM && px > -SIDE_PX_LIM);
         MOUNT_RIGHT:
            keep = !(b[AXIS_Z] > BZ_MAX || up_data.lt_yx_40)
                 && (py < -SIDE_PY_MIN && px < SIDE_PX_LIM && px > -SIDE_PX_LIM);
         MOUNT_REAR:
            keep = !(up_data.lt_zy_view || up_data.lt_zx_view)
                 && (b[AXIS_Z] < REAR_BZ_MAX
                     && b[AXIS_Y] >= -REAR_BY_LIM && b[AXIS_Y] <= REAR_BY_LIM
                     && b[AXIS_X] < REAR_BX_LIM && b[AXIS_X] > -REAR_BX_LIM);
         default:
            keep = 1'b1;
      endcase
   end

   // a dropped point simply leaves no beat behind
   assign v_in = up_ready ? (up_valid & keep) : v_ff;

   always_comb begin
      o_in.xyz   = {b[AXIS_Z], b[AXIS_Y], b[AXIS_X]};
      o_in.blue  = up_data.pix.blue;
      o_in.green = up_data.pix.green;
      o_in.red   = up_data.pix.red;
   end

   always_ff @(posedge clock) begin
      if (reset)
         v_ff <= 1'b0;
      else
         v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (up_valid & up_ready)
         o_ff <= o_in;
   end

   assign dn_valid = v_ff;
   assign dn_data  = o_ff;

endmodule

// ===== sv/point_transform_and_region_filter.sv =====
// top level of the point transform and region filter
//
//  channel  ports   direction  beat contents
//  -------  ------  ---------  -------------------------------------------------
//  req      req_*   in         camera point xyz (mm) and blue, green, red
//  rsp      rsp_*   out        kept body-frame point xyz (mm) and red, green, blue
//  csr      csr_*   in/out     apb-style register port, 64-bit data, reg i at 8*i
//
//  one beat accepted every cycle while rsp is not stalled
//  stages: input capture, multipliers, product sums and ratio compares, offset,
//  saturation and crop decision into the output register
//  dropped points leave a bubble and no rsp beat
//  synchronous active-high reset clears the stage valids and loads register defaults
//  a stall on rsp fills the stage registers back to req_tready; nothing lost or doubled
module point_transform_and_region_filter import ptrf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input point stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // cam_x, cam_y, cam_z, color_blue, color_green, color_red
   // kept point stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // body_x, body_y, body_z, out_red, out_green, out_blue
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type  cfg;
   pix_type  in_pix;
   prod_type mul_data;
   sum_type  sum_data;
   pix_type  out_pix;
   logic     mul_valid, mul_ready;
   logic     sum_valid, sum_ready;

   // unpack the input beat
   assign in_pix.xyz   = req_tdata[47:0];
   assign in_pix.blue  = req_tdata[55:48];
   assign in_pix.green = req_tdata[63:56];
   assign in_pix.red   = req_tdata[71:64];

   ptrf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // capture and multiply, two register stages
   ptrf_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (in_pix),
      .dn_valid (mul_valid),
      .dn_ready (mul_ready),
      .dn_data  (mul_data)
   );

   // rounded sums and ratio flags
   ptrf_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mul_valid),
      .up_ready (mul_ready),
      .up_data  (mul_data),
      .dn_valid (sum_valid),
      .dn_ready (sum_ready),
      .dn_data  (sum_data)
   );

   // offset, saturate, crop and hold the result beat
   ptrf_crop u_crop (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (sum_valid),
      .up_ready (sum_ready),
      .up_data  (sum_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (out_pix)
   );

   // output colors go out red first
   assign rsp_tdata = {out_pix.blue, out_pix.green, out_pix.red, out_pix.xyz};

endmodule
